>>> rtl/core/slr_pkg.sv
package slr_pkg;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_STAGE1  = 3'd0,
		CFG_STAGE2  = 3'd1,
		CFG_STAGE3  = 3'd2,
		CFG_STAGE4  = 3'd3,
		CFG_OVERREV = 3'd4
	} cfg_idx_t;

	localparam logic [CFG_W-1:0] STAGE1_RESET    = 16'd5000;
	localparam logic [CFG_W-1:0] STAGE2_RESET    = 16'd6000;
	localparam logic [CFG_W-1:0] STAGE3_RESET    = 16'd6800;
	localparam logic [CFG_W-1:0] STAGE4_RESET    = 16'd7400;
	localparam logic [CFG_W-1:0] DEFAULT_OVERREV = 16'd7800;

	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic [3:0][CFG_W-1:0] stage_thr;
		logic [CFG_W-1:0]      overrev;
	} cfg_t;

	typedef struct packed {
		logic [15:0] rpm;
		logic [5:0]  flags;
		logic [31:0] now_ms;
	} request_t;

	typedef struct packed {
		logic [3:0] led_index;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       last;
	} result_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	localparam rgb_t COL_OFF        = '{8'd0,   8'd0,   8'd0};
	localparam rgb_t COL_FLAG_RED   = '{8'd220, 8'd0,   8'd0};
	localparam rgb_t COL_YELLOW     = '{8'd180, 8'd140, 8'd0};
	localparam rgb_t COL_BLUE       = '{8'd0,   8'd50,  8'd220};
	localparam rgb_t COL_TC         = '{8'd200, 8'd90,  8'd0};
	localparam rgb_t COL_ABS        = '{8'd0,   8'd160, 8'd200};
	localparam rgb_t COL_BAR_GREEN  = '{8'd0,   8'd50,  8'd0};
	localparam rgb_t COL_BAR_YELLOW = '{8'd50,  8'd35,  8'd0};
	localparam rgb_t COL_BAR_RED    = '{8'd50,  8'd0,   8'd0};

	// one classified frame, handed from the front to the LED sequencer
	typedef struct packed {
		logic [2:0] stage;
		logic       pit;
		logic       pit_on;
		logic       red_hide;
		logic       flag_on;
		rgb_t       flag_rgb;
		logic       aid_on;
		rgb_t       aid_rgb;
	} frame_t;

endpackage

>>> rtl/core/shift_light_dashboard_renderer_top.sv
// channel   direction  handshake          payload
// request   in         push / full        request_t: rpm, flags, now_ms
// result    out        empty / pop        result_t: led_index, red, green, blue, last
// config    in         wr_en              wr_index, wr_data (16 bits)
//
// One result per cycle while pop keeps taking them: a frame is STRIP_LEDS results, set by the LED sequencer.
// A request reaches its first result through the front stages, the queue, the sequencer frame register
// and the output register, in that order; the front keeps accepting while the sequencer works.
// Reset clears pipeline, queue and output valids; thresholds return to their defaults.
// pop low holds the result; the sequencer, then the two-frame queue, then full follow.
module shift_light_dashboard_renderer_top import slr_pkg::*; #(
	parameter int STRIP_LEDS      = 12,
	parameter int BAR_LEDS        = 8,
	parameter int BAR_FIRST       = 2,
	parameter int FLAG_PAIR_FIRST = 0,
	parameter int AID_PAIR_FIRST  = 10
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  request_t             request,
	output logic                 empty,
	input  logic                 pop,
	output result_t              result,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [CFG_W-1:0]     wr_data
);

	cfg_t   cfg_q;
	logic   fr_valid;
	frame_t fr_data;
	logic   q_full;
	logic   q_empty;
	frame_t q_data;
	logic   q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.stage_thr[0] <= STAGE1_RESET;
			cfg_q.stage_thr[1] <= STAGE2_RESET;
			cfg_q.stage_thr[2] <= STAGE3_RESET;
			cfg_q.stage_thr[3] <= STAGE4_RESET;
			cfg_q.overrev      <= '0;
		end else if (wr_en) begin
			case (wr_index)
				CFG_STAGE1:  cfg_q.stage_thr[0] <= wr_data;
				CFG_STAGE2:  cfg_q.stage_thr[1] <= wr_data;
				CFG_STAGE3:  cfg_q.stage_thr[2] <= wr_data;
				CFG_STAGE4:  cfg_q.stage_thr[3] <= wr_data;
				CFG_OVERREV: cfg_q.overrev      <= wr_data;
				default: begin
				end
			endcase
		end
	end

	slr_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.push        (push),
		.full        (full),
		.request     (request),
		.frame_valid (fr_valid),
		.frame       (fr_data),
		.frame_full  (q_full)
	);

	slr_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fr_valid),
		.din    (fr_data),
		.full   (q_full),
		.pop    (q_pop),
		.dout   (q_data),
		.empty  (q_empty)
	);

	slr_back #(
		.STRIP_LEDS      (STRIP_LEDS),
		.BAR_LEDS        (BAR_LEDS),
		.BAR_FIRST       (BAR_FIRST),
		.FLAG_PAIR_FIRST (FLAG_PAIR_FIRST),
		.AID_PAIR_FIRST  (AID_PAIR_FIRST)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.frame_empty (q_empty),
		.frame       (q_data),
		.frame_pop   (q_pop),
		.result      (result),
		.empty       (empty),
		.pop         (pop)
	);

endmodule

>>> rtl/core/slr_front.sv
module slr_front import slr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  cfg_t     cfg,
	input  logic     push,
	output logic     full,
	input  request_t request,
	output logic     frame_valid,
	output frame_t   frame,
	input  logic     frame_full
);

	localparam logic [29:0] RECIP5  = 30'd858993459;
	localparam logic [26:0] RECIP35 = 27'd122713351;
	localparam logic [26:0] RECIP45 = 27'd95443717;

	localparam int FLG_RED    = 0;
	localparam int FLG_YELLOW = 1;
	localparam int FLG_BLUE   = 2;
	localparam int FLG_TC     = 3;
	localparam int FLG_ABS    = 4;
	localparam int FLG_PIT    = 5;

	localparam int FLAG_SLOT = 280;
	localparam int FLAG_ON   = FLAG_SLOT * 4 / 5;
	localparam int AID_SLOT  = 320;
	localparam int AID_ON    = AID_SLOT * 4 / 5;

	logic        en;
	logic        accept;

	logic        v_s1;
	logic [57:0] prod5_s1;
	logic [56:0] prod35_s1;
	logic [57:0] prod45_s1;
	logic [31:0] now_s1;
	logic [5:0]  flags_s1;
	logic [2:0]  stage_s1;
	logic        overrev_s1;

	logic        v_s2;
	logic [25:0] q5_s2;
	logic [24:0] q35_s2;
	logic [25:0] q45_s2;
	logic [9:0]  now_lo_s2;
	logic [5:0]  flags_s2;
	logic [2:0]  stage_s2;
	logic        overrev_s2;

	logic        v_s3;
	frame_t      frame_s3;

	logic [2:0]  stage_d;
	logic [15:0] over_at;
	logic [25:0] qe5;
	logic [24:0] qe35;
	logic [25:0] qe45;
	logic [31:0] r5;
	logic [31:0] r35;
	logic [31:0] r45;
	logic [9:0]  t560;
	logic [9:0]  t640;
	frame_t      frame_d;

	assign en          = !(v_s3 && frame_full);
	assign full        = !en;
	assign accept      = push && en;
	assign frame_valid = v_s3;
	assign frame       = frame_s3;

	always_comb begin
		if (request.rpm == 16'd0) begin
			stage_d = 3'd0;
		end else if (request.rpm >= cfg.stage_thr[3]) begin
			stage_d = 3'd4;
		end else if (request.rpm >= cfg.stage_thr[2]) begin
			stage_d = 3'd3;
		end else if (request.rpm >= cfg.stage_thr[1]) begin
			stage_d = 3'd2;
		end else if (request.rpm >= cfg.stage_thr[0]) begin
			stage_d = 3'd1;
		end else begin
			stage_d = 3'd0;
		end
		over_at = (cfg.overrev == 16'd0) ? DEFAULT_OVERREV : cfg.overrev;
	end

	always_comb begin
		qe5  = prod5_s1[57:32];
		qe35 = prod35_s1[56:32];
		qe45 = prod45_s1[57:32];
		r5   = 32'(now_s1[31:4]) - 32'(qe5) * 32'd5;
		r35  = 32'(now_s1[31:2]) - 32'(qe35) * 32'd35;
		r45  = 32'(now_s1[31:1]) - 32'(qe45) * 32'd45;
	end

	always_comb begin
		t640 = now_lo_s2 - 10'(q5_s2[25:3] * 10'd640);
		t560 = now_lo_s2 - 10'(q35_s2[24:2] * 10'd560);

		frame_d          = '0;
		frame_d.stage    = stage_s2;
		frame_d.pit      = flags_s2[FLG_PIT];
		frame_d.pit_on   = q35_s2[0];
		frame_d.red_hide = overrev_s2 && !q5_s2[0];
		frame_d.flag_rgb = COL_OFF;
		frame_d.aid_rgb  = COL_OFF;

		if (flags_s2[FLG_RED]) begin
			frame_d.flag_on  = q45_s2[0];
			frame_d.flag_rgb = COL_FLAG_RED;
		end else if (flags_s2[FLG_YELLOW] && flags_s2[FLG_BLUE]) begin
			if (t560 < 10'(FLAG_ON)) begin
				frame_d.flag_on  = 1'b1;
				frame_d.flag_rgb = COL_YELLOW;
			end else if (t560 >= 10'(FLAG_SLOT) && t560 < 10'(FLAG_SLOT + FLAG_ON)) begin
				frame_d.flag_on  = 1'b1;
				frame_d.flag_rgb = COL_BLUE;
			end
		end else if (flags_s2[FLG_YELLOW]) begin
			frame_d.flag_on  = q5_s2[1];
			frame_d.flag_rgb = COL_YELLOW;
		end else if (flags_s2[FLG_BLUE]) begin
			frame_d.flag_on  = q5_s2[1];
			frame_d.flag_rgb = COL_BLUE;
		end

		if (flags_s2[FLG_TC] && flags_s2[FLG_ABS]) begin
			if (t640 < 10'(AID_ON)) begin
				frame_d.aid_on  = 1'b1;
				frame_d.aid_rgb = COL_TC;
			end else if (t640 >= 10'(AID_SLOT) && t640 < 10'(AID_SLOT + AID_ON)) begin
				frame_d.aid_on  = 1'b1;
				frame_d.aid_rgb = COL_ABS;
			end
		end else if (flags_s2[FLG_TC]) begin
			frame_d.aid_on  = q45_s2[1];
			frame_d.aid_rgb = COL_TC;
		end else if (flags_s2[FLG_ABS]) begin
			frame_d.aid_on  = q45_s2[1];
			frame_d.aid_rgb = COL_ABS;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod5_s1   <= request.now_ms[31:4] * RECIP5;
			prod35_s1  <= request.now_ms[31:2] * RECIP35;
			prod45_s1  <= request.now_ms[31:1] * RECIP45;
			now_s1     <= request.now_ms;
			flags_s1   <= request.flags;
			stage_s1   <= stage_d;
			overrev_s1 <= request.rpm >= over_at;

			q5_s2      <= qe5 + 26'(r5 >= 32'd5);
			q35_s2     <= qe35 + 25'(r35 >= 32'd35);
			q45_s2     <= qe45 + 26'(r45 >= 32'd45);
			now_lo_s2  <= now_s1[9:0];
			flags_s2   <= flags_s1;
			stage_s2   <= stage_s1;
			overrev_s2 <= overrev_s1;

			frame_s3   <= frame_d;
		end
	end

endmodule

>>> rtl/core/slr_queue.sv
module slr_queue import slr_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  frame_t din,
	output logic   full,
	input  logic   pop,
	output frame_t dout,
	output logic   empty
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	frame_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push;
	logic               do_pop;

	assign full    = count_q == CNT_W'(QUEUE_DEPTH);
	assign empty   = count_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

endmodule

>>> rtl/core/slr_back.sv
module slr_back import slr_pkg::*; #(
	parameter int STRIP_LEDS      = 12,
	parameter int BAR_LEDS        = 8,
	parameter int BAR_FIRST       = 2,
	parameter int FLAG_PAIR_FIRST = 0,
	parameter int AID_PAIR_FIRST  = 10
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    frame_empty,
	input  frame_t  frame,
	output logic    frame_pop,
	output result_t result,
	output logic    empty,
	input  logic    pop
);

	localparam int IDX_W    = $clog2(STRIP_LEDS);
	localparam int LIT_W    = $clog2(BAR_LEDS + 1);
	localparam int SPAN     = (BAR_LEDS + 3) / 4;
	localparam int LIT1_RAW = SPAN;
	localparam int LIT2_RAW = BAR_LEDS / 4 + SPAN;
	localparam int LIT3_RAW = (2 * BAR_LEDS) / 4 + SPAN;
	localparam int LIT1     = (LIT1_RAW > BAR_LEDS) ? BAR_LEDS : LIT1_RAW;
	localparam int LIT2     = (LIT2_RAW > BAR_LEDS) ? BAR_LEDS : LIT2_RAW;
	localparam int LIT3     = (LIT3_RAW > BAR_LEDS) ? BAR_LEDS : LIT3_RAW;
	localparam int BAR_END  = BAR_FIRST + BAR_LEDS;
	localparam int YELLOW_FROM = 3;
	localparam int RED_FROM    = 5;

	logic             busy_q;
	logic [IDX_W-1:0] idx_q;
	frame_t           cur_q;
	result_t          res_q;
	logic             res_v_q;

	logic             advance;
	logic             last_led;
	logic             take;
	logic [IDX_W-1:0] bar_pos;
	logic             in_bar;
	logic [LIT_W-1:0] lit;
	rgb_t             rgb;

	assign advance   = !res_v_q || pop;
	assign last_led  = idx_q == IDX_W'(STRIP_LEDS - 1);
	assign take      = advance && (!busy_q || last_led) && !frame_empty;
	assign frame_pop = take;
	assign empty     = !res_v_q;
	assign result    = res_q;

	always_comb begin
		case (cur_q.stage)
			3'd1:    lit = LIT_W'(LIT1);
			3'd2:    lit = LIT_W'(LIT2);
			3'd3:    lit = LIT_W'(LIT3);
			3'd4:    lit = LIT_W'(BAR_LEDS);
			default: lit = '0;
		endcase

		in_bar  = (idx_q >= BAR_FIRST) && (idx_q < BAR_END);
		bar_pos = IDX_W'(idx_q - BAR_FIRST);
		rgb     = COL_OFF;

		if (in_bar) begin
			if (cur_q.pit) begin
				if (cur_q.pit_on) begin
					rgb = COL_YELLOW;
				end
			end else if (bar_pos < lit) begin
				if (bar_pos >= RED_FROM) begin
					if (!cur_q.red_hide) begin
						rgb = COL_BAR_RED;
					end
				end else if (bar_pos >= YELLOW_FROM) begin
					rgb = COL_BAR_YELLOW;
				end else begin
					rgb = COL_BAR_GREEN;
				end
			end
		end

		if (cur_q.flag_on && (idx_q == FLAG_PAIR_FIRST || idx_q == FLAG_PAIR_FIRST + 1)) begin
			rgb = cur_q.flag_rgb;
		end
		if (cur_q.aid_on && (idx_q == AID_PAIR_FIRST || idx_q == AID_PAIR_FIRST + 1)) begin
			rgb = cur_q.aid_rgb;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			idx_q   <= '0;
			res_v_q <= 1'b0;
		end else if (advance) begin
			res_v_q <= busy_q;
			if (busy_q) begin
				idx_q <= idx_q + 1'b1;
				if (last_led) begin
					busy_q <= 1'b0;
				end
			end
			if (take) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cur_q <= frame;
		end
		if (advance && busy_q) begin
			res_q.led_index <= 4'(idx_q);
			res_q.red       <= rgb.red;
			res_q.green     <= rgb.green;
			res_q.blue      <= rgb.blue;
			res_q.last      <= last_led;
		end
	end

endmodule
